// ===== src/ctef_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath interface types for the easing unit.
package ctef_pkg;

  // Fixed-point format of progress, control points and results.
  localparam int FRAC_BITS  = 16;
  localparam int ONE        = 1 << FRAC_BITS;

  localparam int PROG_W     = 19;
  localparam int OUT_W      = 20;
  localparam int CX_W       = FRAC_BITS + 1;
  localparam int CY_W       = 20;
  localparam int N_W        = 16;
  localparam int T_W        = FRAC_BITS + 1;
  localparam int V_W        = N_W + 1;
  localparam int ACC_W      = 26;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // |x(t) - p| * 100000 < ONE, rewritten as |x(t) - p| < EPS_LIM.
  localparam int EPS_LIM    = (ONE - 1) / 100000 + 1;

  localparam logic signed [ACC_W-1:0]  ONE_ACC     = ACC_W'(ONE);
  localparam logic signed [ACC_W-1:0]  EPS_ACC     = ACC_W'(EPS_LIM);
  localparam logic signed [ACC_W-1:0]  OUT_MAX_ACC = ACC_W'(524287);
  localparam logic signed [ACC_W-1:0]  OUT_MIN_ACC = -ACC_W'(524288);
  localparam logic signed [OUT_W-1:0]  OUT_MAX     = OUT_W'(524287);
  localparam logic signed [OUT_W-1:0]  OUT_MIN     = OUT_W'(524288);
  localparam logic signed [OUT_W-1:0]  OUT_ONE     = OUT_W'(ONE);
  localparam logic signed [PROG_W-1:0] ONE_P       = PROG_W'(ONE);
  localparam logic [CX_W-1:0]          ONE_X       = CX_W'(ONE);
  localparam logic [T_W-1:0]           ONE_T       = T_W'(ONE);

  // Register reset values.
  localparam logic [CX_W-1:0]         CTRL_X_RST  = CX_W'(ONE / 4);
  localparam logic signed [CY_W-1:0]  CTRL_Y1_RST = CY_W'((ONE + 5) / 10);
  localparam logic signed [CY_W-1:0]  CTRL_Y2_RST = CY_W'(ONE);
  localparam logic [N_W-1:0]          STEP_RST    = N_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CURVE_MODE,
    REG_CTRL_X1,
    REG_CTRL_Y1,
    REG_CTRL_X2,
    REG_CTRL_Y2,
    REG_STEP_COUNT,
    REG_JUMP_AT_START
  } cfg_reg_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_ONE,
    RES_BEZ,
    RES_STEP
  } res_sel_e;

  typedef enum logic [1:0] {
    MAC_B,
    MAC_C,
    MAC_NONE
  } mac_sel_e;

  typedef struct packed {
    logic     load;
    logic     acc_init;
    logic     sel_y;
    logic     mac_en;
    mac_sel_e mac_sel;
    logic     bisect;
    logic     step_mul;
    logic     div_init;
    logic     div_step;
    logic     out_load;
    res_sel_e out_sel;
  } cmd_t;

  typedef struct packed {
    logic p_le0;
    logic p_ge1;
    logic x_hit;
    logic t_open;
  } sts_t;

endpackage

// ===== src/css_timing_function_ease_top.sv =====
`timescale 1ns / 1ps
// Top level of the easing unit: configuration registers, controller and datapath.
//
// Maps one animation progress value (signed Q16) to an eased value (signed Q16).
// Input channel: in_valid_i / in_ready_o with progress_in_i; a transfer happens
// when both are high. Output channel: out_valid_o / out_ready_i with eased_value_o.
// Configuration: write cfg_data_i to register cfg_index_i while cfg_we_i is high;
// write only while no item is in flight. Unknown indexes are dropped.
//
// One item is worked on at a time. Path from input transfer to output valid:
//   progress at or below 0, or at or above 1.0: S_CLASS, then S_FIN
//   stepped curve: one multiply, then one quotient bit per cycle
//   bezier curve: up to MAX_ITERS bisection steps, then the y evaluation; each
//   bisection step runs S_XTEST, S_XM and S_XCMP through the single shared Horner multiplier.
// The next input transfer can come in the cycle after the result is loaded
// into the output register in S_FIN.
// The result sits in an output register, so a new item is taken while the last
// result still waits; if the receiver stalls, the next result holds in the
// controller until the output register frees up.
// Reset clears the controller and loads the register defaults; no memories.
module css_timing_function_ease_top import ctef_pkg::*; #(
  parameter int MAX_ITERS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [PROG_W-1:0]     progress_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [OUT_W-1:0]      eased_value_o
);

  logic                   curve_mode_q;
  logic [CX_W-1:0]        ctrl_x1_q, ctrl_x2_q;
  logic signed [CY_W-1:0] ctrl_y1_q, ctrl_y2_q;
  logic [N_W-1:0]         step_count_q;
  logic                   jump_at_start_q;

  cmd_t cmd;
  sts_t sts;

  // Configuration registers: take each write directly, masked to its width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_mode_q    <= 1'b0;
      ctrl_x1_q       <= CTRL_X_RST;
      ctrl_y1_q       <= CTRL_Y1_RST;
      ctrl_x2_q       <= CTRL_X_RST;
      ctrl_y2_q       <= CTRL_Y2_RST;
      step_count_q    <= STEP_RST;
      jump_at_start_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CURVE_MODE:    curve_mode_q    <= cfg_data_i[0];
        REG_CTRL_X1:       ctrl_x1_q       <= cfg_data_i[CX_W-1:0];
        REG_CTRL_Y1:       ctrl_y1_q       <= $signed(cfg_data_i[CY_W-1:0]);
        REG_CTRL_X2:       ctrl_x2_q       <= cfg_data_i[CX_W-1:0];
        REG_CTRL_Y2:       ctrl_y2_q       <= $signed(cfg_data_i[CY_W-1:0]);
        REG_STEP_COUNT:    step_count_q    <= cfg_data_i[N_W-1:0];
        REG_JUMP_AT_START: jump_at_start_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer: owns both handshakes and steps the datapath.
  ctef_ctrl #(
    .MAX_ITERS (MAX_ITERS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .curve_mode_i (curve_mode_q),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // Arithmetic: Horner evaluator, bisection bounds, stepped-curve divider, output register.
  ctef_dpath u_dpath (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .progress_in_i   (progress_in_i),
    .x1_i            (ctrl_x1_q),
    .y1_i            (ctrl_y1_q),
    .x2_i            (ctrl_x2_q),
    .y2_i            (ctrl_y2_q),
    .step_count_i    (step_count_q),
    .jump_at_start_i (jump_at_start_q),
    .eased_value_o   (eased_value_o)
  );

endmodule

// ===== src/ctef_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: shared cubic evaluator, bisection bounds, step multiplier and divider.
module ctef_dpath import ctef_pkg::*; (
  input  logic                     clk_i,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  input  logic signed [PROG_W-1:0] progress_in_i,
  input  logic [CX_W-1:0]          x1_i,
  input  logic signed [CY_W-1:0]   y1_i,
  input  logic [CX_W-1:0]          x2_i,
  input  logic signed [CY_W-1:0]   y2_i,
  input  logic [N_W-1:0]           step_count_i,
  input  logic                     jump_at_start_i,
  output logic signed [OUT_W-1:0]  eased_value_o
);

  logic signed [PROG_W-1:0] p_q;
  logic [T_W-1:0]           t_q, tmin_q, tmax_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [V_W-1:0]           v_q;
  logic [N_W-1:0]           rem_q;
  logic [FRAC_BITS:0]       quo_q;
  logic signed [OUT_W-1:0]  out_q;

  logic [CX_W-1:0]          x1c, x2c;
  logic signed [ACC_W-1:0]  c1, c2, thr1, thr2, coef_a, coef_b, coef_c;
  logic signed [ACC_W-1:0]  addend, mac_d, p_ext, diff, diff_abs;
  logic signed [ACC_W+T_W:0] prod, prod_sh;
  logic                     p_gt_s;
  logic [T_W-1:0]           tmin_n, tmax_n;
  logic [T_W:0]             t_sum;
  logic [N_W-1:0]           n_eff;
  logic [FRAC_BITS+N_W-1:0] sprod;
  logic [V_W-1:0]           v_sub, r2, r_sub;
  logic                     v_ge, r_ge;
  logic signed [OUT_W-1:0]  out_d;

  // Clamp control x to one.
  assign x1c = (x1_i > ONE_X) ? ONE_X : x1_i;
  assign x2c = (x2_i > ONE_X) ? ONE_X : x2_i;

  assign c1 = cmd_i.sel_y ? ACC_W'(y1_i) : $signed({{(ACC_W-CX_W){1'b0}}, x1c});
  assign c2 = cmd_i.sel_y ? ACC_W'(y2_i) : $signed({{(ACC_W-CX_W){1'b0}}, x2c});

  assign thr1   = (c1 <<< 1) + c1;
  assign thr2   = (c2 <<< 1) + c2;
  assign coef_a = ONE_ACC + thr1 - thr2;
  assign coef_b = thr2 - (thr1 <<< 1);
  assign coef_c = thr1;

  always_comb begin
    case (cmd_i.mac_sel)
      MAC_B:   addend = coef_b;
      MAC_C:   addend = coef_c;
      default: addend = '0;
    endcase
  end

  // One Horner step: floor(acc * t / ONE) + addend.
  assign prod    = acc_q * $signed({1'b0, t_q});
  assign prod_sh = prod >>> FRAC_BITS;
  assign mac_d   = $signed(prod_sh[ACC_W-1:0]) + addend;

  assign p_ext    = ACC_W'(p_q);
  assign diff     = acc_q - p_ext;
  assign diff_abs = diff[ACC_W-1] ? -diff : diff;
  assign p_gt_s   = p_ext > acc_q;

  assign tmin_n = p_gt_s ? t_q : tmin_q;
  assign tmax_n = p_gt_s ? tmax_q : t_q;
  assign t_sum  = {1'b0, tmin_n} + {1'b0, tmax_n};

  // Stepped curve: k = floor(p * n / ONE), then (k + jump) * ONE / n bit by bit.
  assign n_eff = (step_count_i == '0) ? N_W'(1) : step_count_i;
  assign sprod = p_q[FRAC_BITS-1:0] * n_eff;
  assign v_ge  = v_q >= {1'b0, n_eff};
  assign v_sub = v_q - {1'b0, n_eff};
  assign r2    = {rem_q, 1'b0};
  assign r_ge  = r2 >= {1'b0, n_eff};
  assign r_sub = r2 - {1'b0, n_eff};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p_q    <= progress_in_i;
      t_q    <= {1'b0, progress_in_i[FRAC_BITS-1:0]};
      tmin_q <= '0;
      tmax_q <= ONE_T;
    end else if (cmd_i.bisect) begin
      tmin_q <= tmin_n;
      tmax_q <= tmax_n;
      t_q    <= t_sum[T_W:1];
    end
    if (cmd_i.acc_init) begin
      acc_q <= coef_a;
    end else if (cmd_i.mac_en) begin
      acc_q <= mac_d;
    end
    if (cmd_i.step_mul) begin
      v_q <= {1'b0, sprod[FRAC_BITS+N_W-1:FRAC_BITS]} + {{N_W{1'b0}}, jump_at_start_i};
    end
    if (cmd_i.div_init) begin
      rem_q <= v_ge ? v_sub[N_W-1:0] : v_q[N_W-1:0];
      quo_q <= {{FRAC_BITS{1'b0}}, v_ge};
    end else if (cmd_i.div_step) begin
      rem_q <= r_ge ? r_sub[N_W-1:0] : r2[N_W-1:0];
      quo_q <= {quo_q[FRAC_BITS-1:0], r_ge};
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    case (cmd_i.out_sel)
      RES_ZERO: out_d = '0;
      RES_ONE:  out_d = OUT_ONE;
      RES_BEZ: begin
        if (acc_q > OUT_MAX_ACC) begin
          out_d = OUT_MAX;
        end else if (acc_q < OUT_MIN_ACC) begin
          out_d = OUT_MIN;
        end else begin
          out_d = acc_q[OUT_W-1:0];
        end
      end
      default:  out_d = $signed({{(OUT_W-FRAC_BITS-1){1'b0}}, quo_q});
    endcase
  end

  assign sts_o.p_le0  = p_q[PROG_W-1] || (p_q == '0);
  assign sts_o.p_ge1  = p_q >= ONE_P;
  assign sts_o.x_hit  = diff_abs < EPS_ACC;
  assign sts_o.t_open = tmin_q < tmax_q;

  assign eased_value_o = out_q;

endmodule

// ===== src/ctef_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences bisection, curve evaluation, step division and the output register.
module ctef_ctrl import ctef_pkg::*; #(
  parameter int MAX_ITERS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  logic curve_mode_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam int MAX_CNT = (MAX_ITERS > FRAC_BITS) ? MAX_ITERS : FRAC_BITS;
  localparam int ITER_W  = $clog2(MAX_CNT + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLASS = 4'd1;
  localparam logic [3:0] S_XTEST = 4'd2;
  localparam logic [3:0] S_XM    = 4'd3;
  localparam logic [3:0] S_XCMP  = 4'd4;
  localparam logic [3:0] S_Y0    = 4'd5;
  localparam logic [3:0] S_YM    = 4'd6;
  localparam logic [3:0] S_SMUL  = 4'd7;
  localparam logic [3:0] S_SDIV0 = 4'd8;
  localparam logic [3:0] S_SDIV  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0]        state_q, state_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic [1:0]        mstep_q, mstep_d;
  res_sel_e          res_sel_q, res_sel_d;
  logic              out_valid_q, out_valid_d;
  mac_sel_e          mac_sel;

  always_comb begin
    case (mstep_q)
      2'd0:    mac_sel = MAC_B;
      2'd1:    mac_sel = MAC_C;
      default: mac_sel = MAC_NONE;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    iter_d    = iter_q;
    mstep_d   = mstep_q;
    res_sel_d = res_sel_q;
    cmd_o     = '0;
    cmd_o.mac_sel = mac_sel;
    cmd_o.out_sel = res_sel_q;
    in_ready_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CLASS;
        end
      end
      S_CLASS: begin
        iter_d  = '0;
        mstep_d = '0;
        if (sts_i.p_le0) begin
          res_sel_d = RES_ZERO;
          state_d   = S_FIN;
        end else if (sts_i.p_ge1) begin
          res_sel_d = RES_ONE;
          state_d   = S_FIN;
        end else if (!curve_mode_i) begin
          state_d = S_XTEST;
        end else begin
          state_d = S_SMUL;
        end
      end
      S_XTEST: begin
        if ((iter_q < ITER_W'(MAX_ITERS)) && sts_i.t_open) begin
          cmd_o.acc_init = 1'b1;
          mstep_d        = '0;
          state_d        = S_XM;
        end else begin
          state_d = S_Y0;
        end
      end
      S_XM: begin
        cmd_o.mac_en = 1'b1;
        mstep_d      = mstep_q + 2'd1;
        if (mstep_q == 2'd2) begin
          state_d = S_XCMP;
        end
      end
      S_XCMP: begin
        if (sts_i.x_hit) begin
          state_d = S_Y0;
        end else begin
          cmd_o.bisect = 1'b1;
          iter_d       = iter_q + ITER_W'(1);
          state_d      = S_XTEST;
        end
      end
      S_Y0: begin
        cmd_o.sel_y    = 1'b1;
        cmd_o.acc_init = 1'b1;
        mstep_d        = '0;
        state_d        = S_YM;
      end
      S_YM: begin
        cmd_o.sel_y  = 1'b1;
        cmd_o.mac_en = 1'b1;
        mstep_d      = mstep_q + 2'd1;
        if (mstep_q == 2'd2) begin
          res_sel_d = RES_BEZ;
          state_d   = S_FIN;
        end
      end
      S_SMUL: begin
        cmd_o.step_mul = 1'b1;
        state_d        = S_SDIV0;
      end
      S_SDIV0: begin
        cmd_o.div_init = 1'b1;
        iter_d         = '0;
        state_d        = S_SDIV;
      end
      S_SDIV: begin
        cmd_o.div_step = 1'b1;
        iter_d         = iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(FRAC_BITS - 1)) begin
          res_sel_d = RES_STEP;
          state_d   = S_FIN;
        end
      end
      S_FIN: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iter_q      <= '0;
      mstep_q     <= '0;
      res_sel_q   <= RES_ZERO;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      mstep_q     <= mstep_d;
      res_sel_q   <= res_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote an untaken result");

  a_accept_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_CLASS))
    else $error("accepted item not classified next");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_XCMP) |-> (iter_q < ITER_W'(MAX_ITERS)))
    else $error("bisection ran past its step limit");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SDIV) |-> (iter_q < ITER_W'(FRAC_BITS)))
    else $error("divider ran past its bit count");

endmodule
